/* hw/rtl/iss_pkg.sv */
// Package for the indexed sequence store: action and status codes,
// sequencer states, and the request and result beat types.
// No dependencies; iss_if, iss_seq and the top level refer to it.
package iss_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 9;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_READ   = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_DEL_ODD  = 3'd3,
    ACT_DEL_EVEN = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_FULL  = 3'd3,
    ST_NONE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RDWAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
    logic signed [INDEX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    status_e                   status;
    logic [COUNT_W-1:0]        count;
  } res_t;

endpackage

/* hw/rtl/iss_if.sv */
// Valid/ready channel interfaces for the indexed sequence store:
// one for request beats, one for result beats. Depends on iss_pkg.
interface iss_in_if;
  logic                                valid;
  logic                                ready;
  logic [iss_pkg::ACTION_W-1:0]        action;
  logic signed [iss_pkg::VALUE_W-1:0]  value;
  logic signed [iss_pkg::INDEX_W-1:0]  index;

  modport source (output valid, action, value, index, input ready);
  modport sink   (input valid, action, value, index, output ready);
endinterface

interface iss_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [iss_pkg::VALUE_W-1:0]  read_value;
  logic [iss_pkg::STATUS_W-1:0]        status;
  logic [iss_pkg::COUNT_W-1:0]         count;

  modport source (output valid, read_value, status, count, input ready);
  modport sink   (input valid, read_value, status, count, output ready);
endinterface

/* hw/rtl/indexed_sequence_store_core.sv */
// Top level of the indexed sequence store: channel interfaces, sequencer
// and the result output register. Depends on iss_pkg, iss_if and iss_seq.
//
// Usage: request beats (action, value, index) enter on in_i; each request
// yields exactly one result beat (read_value, status, count) on out_o.
// Append, clear, rejected actions and unused codes go straight to the result
// state in the sequencer; read waits on one memory read. Delete by index
// scans from its position, a parity delete the whole store, moving one entry
// per cycle through the single-write, single-read entry memory. A result
// leaving the sequencer shows on out_o in the next cycle.
// in_i.ready is high only while the sequencer is idle; it returns to idle as
// soon as its result moves into the output register, so the next request is
// taken while a result still waits on a stalled out_o. A stall longer than
// that holds the sequencer with its result. Reset empties the store (count
// zero) at once; there is no clearing pass, entry contents are undefined
// until written.
module indexed_sequence_store_core #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  iss_in_if.sink    in_i,
  iss_out_if.source out_o
);

  iss_pkg::req_t req;
  iss_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;
  logic          in_ready;
  logic          out_valid_q, out_valid_d;
  iss_pkg::res_t out_res_q;

  assign req.action = in_i.action;
  assign req.value  = in_i.value;
  assign req.index  = in_i.index;
  assign in_i.ready = in_ready;

  iss_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // take a result when the output slot is free or drains this cycle
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // hold the result beat payload
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_res_q.read_value;
  assign out_o.status     = out_res_q.status;
  assign out_o.count      = out_res_q.count;

  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_q)
    else $error("result beat lost on its way to the output register");

endmodule

/* hw/rtl/iss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/iss_seq.sv */
// Sequencer and entry memory of the indexed sequence store: decodes a
// request beat, runs the one-entry-per-cycle compaction scan, builds the result.
// Depends on iss_pkg and iss_ram.
module iss_seq #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  iss_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output iss_pkg::res_t res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = ((CW > iss_pkg::INDEX_W) ? CW : iss_pkg::INDEX_W) + 1;

  iss_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    rd_q, rd_d;
  logic [CW-1:0]    wr_q, wr_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_idx_q, pend_idx_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic             del_q, del_d;
  logic             drop_q, drop_d;
  logic [iss_pkg::VALUE_W-1:0] rv_q, rv_d;
  iss_pkg::status_e st_q, st_d;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [iss_pkg::VALUE_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [iss_pkg::VALUE_W-1:0] ram_rdata;

  logic              accept;
  iss_pkg::action_e  act;
  logic              full;
  logic              empty;
  logic signed [IW-1:0] idx_ext;
  logic signed [IW-1:0] cnt_ext;
  logic signed [IW-1:0] pos_s;
  logic              in_range;
  logic [AW-1:0]     pos_res;
  logic              scan_more;
  logic              scan_end;
  logic              keep;

  iss_ram #(
    .WIDTH (iss_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_ready_o = (state_q == iss_pkg::S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign act         = iss_pkg::action_e'(req_i.action);
  assign full        = (cnt_q == CW'(CAPACITY));
  assign empty       = (cnt_q == '0);

  // resolve the index: wrap negatives by the count, then bound-check
  assign idx_ext  = IW'(req_i.index);
  assign cnt_ext  = $signed({{(IW - CW){1'b0}}, cnt_q});
  assign pos_s    = idx_ext[IW-1] ? (idx_ext + cnt_ext) : idx_ext;
  assign in_range = !pos_s[IW-1] && (pos_s < cnt_ext);
  assign pos_res  = pos_s[AW-1:0];

  // shared keep test of the compaction scan
  assign scan_more = (rd_q < cnt_q);
  assign scan_end  = !scan_more && !pend_q;
  assign keep      = del_q ? (pend_idx_q != pos_q) : (ram_rdata[0] != drop_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iss_pkg::S_IDLE: begin
        if (accept) begin
          state_d = iss_pkg::S_DONE;
          case (act)
            iss_pkg::ACT_READ: begin
              if (!empty && in_range) state_d = iss_pkg::S_RDWAIT;
            end
            iss_pkg::ACT_DELETE: begin
              if (!empty && in_range) state_d = iss_pkg::S_SCAN;
            end
            iss_pkg::ACT_DEL_ODD, iss_pkg::ACT_DEL_EVEN: begin
              if (!empty) state_d = iss_pkg::S_SCAN;
            end
            default: ;
          endcase
        end
      end
      iss_pkg::S_SCAN: begin
        if (scan_end) state_d = iss_pkg::S_DONE;
      end
      iss_pkg::S_RDWAIT: state_d = iss_pkg::S_DONE;
      iss_pkg::S_DONE: begin
        if (res_ready_i) state_d = iss_pkg::S_IDLE;
      end
      default: state_d = iss_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_d      = cnt_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    pos_d      = pos_q;
    del_d      = del_q;
    drop_d     = drop_q;
    rv_d       = rv_q;
    st_d       = st_q;
    ram_we     = 1'b0;
    ram_waddr  = wr_q[AW-1:0];
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = rd_q[AW-1:0];
    case (state_q)
      iss_pkg::S_IDLE: begin
        if (accept) begin
          st_d   = iss_pkg::ST_OK;
          rv_d   = '0;
          pend_d = 1'b0;
          case (act)
            iss_pkg::ACT_APPEND: begin
              if (full) begin
                st_d = iss_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[AW-1:0];
                ram_wdata = req_i.value;
                cnt_d     = cnt_q + CW'(1);
              end
            end
            iss_pkg::ACT_READ: begin
              if (empty) begin
                st_d = iss_pkg::ST_EMPTY;
              end else if (!in_range) begin
                st_d = iss_pkg::ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = pos_res;
              end
            end
            iss_pkg::ACT_DELETE: begin
              if (empty) begin
                st_d = iss_pkg::ST_EMPTY;
              end else if (!in_range) begin
                st_d = iss_pkg::ST_RANGE;
              end else begin
                rd_d  = CW'(pos_res);
                wr_d  = CW'(pos_res);
                pos_d = pos_res;
                del_d = 1'b1;
              end
            end
            iss_pkg::ACT_DEL_ODD, iss_pkg::ACT_DEL_EVEN: begin
              if (empty) begin
                st_d = iss_pkg::ST_EMPTY;
              end else begin
                rd_d   = '0;
                wr_d   = '0;
                del_d  = 1'b0;
                drop_d = (act == iss_pkg::ACT_DEL_ODD);
              end
            end
            iss_pkg::ACT_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      iss_pkg::S_SCAN: begin
        // issue the next read
        if (scan_more) begin
          ram_re     = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = rd_q[AW-1:0];
          rd_d       = rd_q + CW'(1);
        end else begin
          pend_d = 1'b0;
        end
        // move a kept entry down to the write pointer
        if (pend_q && keep) begin
          ram_we = 1'b1;
          wr_d   = wr_q + CW'(1);
        end
        // close the scan: the write pointer is the new count
        if (scan_end) begin
          cnt_d = wr_q;
          if (!del_q && (wr_q == cnt_q)) st_d = iss_pkg::ST_NONE;
        end
      end
      iss_pkg::S_RDWAIT: rv_d = ram_rdata;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iss_pkg::S_IDLE;
      cnt_q   <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      pend_q  <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    pos_q      <= pos_d;
    del_q      <= del_d;
    drop_q     <= drop_d;
    rv_q       <= rv_d;
    st_q       <= st_d;
  end

  assign res_valid_o      = (state_q == iss_pkg::S_DONE);
  assign res_o.read_value = rv_q;
  assign res_o.status     = st_q;
  assign res_o.count      = iss_pkg::COUNT_W'(cnt_q);

  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iss_pkg::S_SCAN) |-> (wr_q <= rd_q))
    else $error("compaction write pointer passed read pointer");

  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("memory read and write at the same entry");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("count above capacity");

  a_scan_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iss_pkg::S_SCAN && scan_end) |-> (wr_q <= cnt_q))
    else $error("scan would grow the count");

endmodule
